// ===== rtl/core/tbp_pkg.sv =====
// Shared types and defaults for the tournament branch predictor.
`default_nettype none

package tbp_pkg;

  localparam int GLOBAL_HISTORY_BITS_DEF = 12;
  localparam int LOCAL_HISTORY_BITS_DEF  = 10;
  localparam int PC_INDEX_BITS_DEF       = 10;
  localparam int GLOBAL_COUNTER_BITS_DEF = 2;
  localparam int LOCAL_COUNTER_BITS_DEF  = 3;

  localparam int PC_WIDTH     = 10;
  localparam int CHOOSER_BITS = 2;
  localparam int MID_DEPTH    = 2;
  localparam int OUT_DEPTH    = 4;

  typedef struct packed {
    logic [PC_WIDTH-1:0] pc_low_bits;
    logic                taken;
  } tbp_req_t;

  typedef struct packed {
    logic predicted_taken;
    logic chose_global;
    logic mispredicted;
  } tbp_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/tbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tbp_fifo.sv =====
// Small register-based FIFO with occupancy count.
`default_nettype none

module tbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o,
  output logic      [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem[rd_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tbp_front.sv =====
// Front end: accepts branch requests, tags them with global history, queues them.
`default_nettype none

module tbp_front #(
  parameter int GLOBAL_HISTORY_BITS = tbp_pkg::GLOBAL_HISTORY_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           hold_i,
  input  wire logic                           push_i,
  input  wire tbp_pkg::tbp_req_t              req_i,
  output logic                                full_o,
  output logic                                head_valid_o,
  output tbp_pkg::tbp_req_t                   head_req_o,
  output logic [GLOBAL_HISTORY_BITS-1:0]      head_gh_o,
  input  wire logic                           head_pop_i
);

  import tbp_pkg::*;

  localparam int GHB = GLOBAL_HISTORY_BITS;
  localparam int QW  = GHB + $bits(tbp_req_t);

  logic [GHB-1:0] gh_q, gh_d;
  logic           accept;
  logic           q_full, q_empty;
  logic [QW-1:0]  q_data;

  assign full_o       = hold_i || q_full;
  assign accept       = push_i && !full_o;
  assign head_valid_o = !q_empty;
  assign {head_gh_o, head_req_o} = q_data;

  // shift the actual direction into the global history
  assign gh_d = accept ? GHB'({gh_q, req_i.taken}) : gh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gh_q <= '1;
    end else begin
      gh_q <= gh_d;
    end
  end

  tbp_fifo #(
    .WIDTH (QW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  ({gh_q, req_i}),
    .pop_i   (head_pop_i),
    .data_o  (q_data),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o ()
  );

endmodule

`default_nettype wire

// ===== rtl/core/tbp_back.sv =====
// Back end: table lookup, training pipeline with forwarding, reset clearing, result queue.
`default_nettype none

module tbp_back #(
  parameter int GLOBAL_HISTORY_BITS = tbp_pkg::GLOBAL_HISTORY_BITS_DEF,
  parameter int LOCAL_HISTORY_BITS  = tbp_pkg::LOCAL_HISTORY_BITS_DEF,
  parameter int PC_INDEX_BITS       = tbp_pkg::PC_INDEX_BITS_DEF,
  parameter int GLOBAL_COUNTER_BITS = tbp_pkg::GLOBAL_COUNTER_BITS_DEF,
  parameter int LOCAL_COUNTER_BITS  = tbp_pkg::LOCAL_COUNTER_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  output logic                                clearing_o,
  input  wire logic                           head_valid_i,
  input  wire tbp_pkg::tbp_req_t              head_req_i,
  input  wire logic [GLOBAL_HISTORY_BITS-1:0] head_gh_i,
  output logic                                head_pop_o,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output tbp_pkg::tbp_rsp_t                   rsp_o
);

  import tbp_pkg::*;

  localparam int GHB  = GLOBAL_HISTORY_BITS;
  localparam int LHB  = LOCAL_HISTORY_BITS;
  localparam int PIB  = PC_INDEX_BITS;
  localparam int GCB  = GLOBAL_COUNTER_BITS;
  localparam int LCB  = LOCAL_COUNTER_BITS;
  localparam int CB   = CHOOSER_BITS;
  localparam int MXA  = (GHB > LHB) ? GHB : LHB;
  localparam int CLRB = (MXA > PIB) ? MXA : PIB;
  localparam int OCW  = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [CB-1:0]  chooser;
    logic [GCB-1:0] ctr;
  } gc_word_t;

  typedef struct packed {
    logic [PIB-1:0] pc;
    logic [GHB-1:0] gh;
    logic           dir;
  } s1_t;

  typedef struct packed {
    logic [GHB-1:0] gh;
    logic [LHB-1:0] lh;
    logic           dir;
    gc_word_t       gc;
  } s2_t;

  typedef struct packed {
    logic [PIB-1:0] addr;
    logic [LHB-1:0] data;
  } lh_wr_t;

  typedef struct packed {
    logic [GHB-1:0] addr;
    gc_word_t       data;
  } gc_wr_t;

  typedef struct packed {
    logic [LHB-1:0] addr;
    logic [LCB-1:0] data;
  } lc_wr_t;

  localparam gc_word_t GC_INIT = '{chooser: CB'(1 << (CB - 1)), ctr: GCB'(1 << (GCB - 1))};
  localparam logic [LCB-1:0] LC_INIT = LCB'(1 << (LCB - 1));

  // clearing pass
  logic            clearing_q, clearing_d;
  logic [CLRB-1:0] clr_q, clr_d;

  // pipeline
  logic   s1_v_q, s2_v_q;
  s1_t    s1_q, s1_d;
  s2_t    s2_q, s2_d;
  logic   lhw_v_q, gcw_v_q, lcw_v_q;
  lh_wr_t lhw_q, lhw_d;
  gc_wr_t gcw_q, gcw_d;
  lc_wr_t lcw_q, lcw_d;

  logic [PC_WIDTH+PIB-1:0] pc_ext;
  logic [PIB-1:0]          head_pc;
  logic [OCW-1:0]          out_cnt;
  logic [OCW:0]            pending;
  logic                    credit;

  // ram ports
  gc_word_t       gc_rdata, gc_wdata;
  logic [GHB-1:0] gc_waddr;
  logic           gc_we;
  logic [LHB-1:0] lh_rdata, lh_wdata;
  logic [PIB-1:0] lh_waddr;
  logic           lh_we;
  logic [LCB-1:0] lc_rdata, lc_wdata;
  logic [LHB-1:0] lc_waddr;
  logic           lc_we;

  // stage 1 and 2 datapath
  logic [LHB-1:0] lh_eff, lh_new;
  gc_word_t       gc_b1, gc_eff, gc_new;
  logic [LCB-1:0] lc_eff, lc_new;
  logic           g_pred, l_pred, use_g, pred, g_ok, l_ok;
  tbp_rsp_t       rsp_d;

  assign clearing_o = clearing_q;

  assign pc_ext  = {{PIB{1'b0}}, head_req_i.pc_low_bits};
  assign head_pc = pc_ext[PIB-1:0];

  // issue only when the result queue can absorb everything in flight
  assign pending    = {1'b0, out_cnt} + {{OCW{1'b0}}, s1_v_q} + {{OCW{1'b0}}, s2_v_q};
  assign credit     = pending < (OCW + 1)'(OUT_DEPTH);
  assign head_pop_o = head_valid_i && credit && !clearing_q;

  assign s1_d = '{pc: head_pc, gh: head_gh_i, dir: head_req_i.taken};

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + 1'b1;
      if (&clr_q) begin
        clearing_d = 1'b0;
      end
    end
  end

  // stage 1: local history resolve and update, global word first forward
  always_comb begin
    lh_eff = (lhw_v_q && lhw_q.addr == s1_q.pc) ? lhw_q.data : lh_rdata;
    lh_new = LHB'({lh_eff, s1_q.dir});
    gc_b1  = (gcw_v_q && gcw_q.addr == s1_q.gh) ? gcw_q.data : gc_rdata;
    lhw_d  = '{addr: s1_q.pc, data: lh_new};
    s2_d   = '{gh: s1_q.gh, lh: lh_eff, dir: s1_q.dir, gc: gc_b1};
  end

  // stage 2: predict and train
  always_comb begin
    gc_eff = (gcw_v_q && gcw_q.addr == s2_q.gh) ? gcw_q.data : s2_q.gc;
    lc_eff = (lcw_v_q && lcw_q.addr == s2_q.lh) ? lcw_q.data : lc_rdata;
    g_pred = gc_eff.ctr[GCB-1];
    l_pred = lc_eff[LCB-1];
    use_g  = gc_eff.chooser[CB-1];
    pred   = use_g ? g_pred : l_pred;
    g_ok   = (g_pred == s2_q.dir);
    l_ok   = (l_pred == s2_q.dir);

    gc_new = gc_eff;
    if (s2_q.dir) begin
      if (!(&gc_eff.ctr)) gc_new.ctr = gc_eff.ctr + 1'b1;
      if (!(&lc_eff)) lc_new = lc_eff + 1'b1;
      else lc_new = lc_eff;
    end else begin
      if (|gc_eff.ctr) gc_new.ctr = gc_eff.ctr - 1'b1;
      if (|lc_eff) lc_new = lc_eff - 1'b1;
      else lc_new = lc_eff;
    end
    if (g_ok != l_ok) begin
      if (g_ok) begin
        if (!(&gc_eff.chooser)) gc_new.chooser = gc_eff.chooser + 1'b1;
      end else begin
        if (|gc_eff.chooser) gc_new.chooser = gc_eff.chooser - 1'b1;
      end
    end

    gcw_d = '{addr: s2_q.gh, data: gc_new};
    lcw_d = '{addr: s2_q.lh, data: lc_new};
    rsp_d = '{predicted_taken: pred, chose_global: use_g, mispredicted: pred != s2_q.dir};
  end

  // write ports: clearing pass owns them after reset
  always_comb begin
    gc_we    = clearing_q || s2_v_q;
    gc_waddr = clearing_q ? clr_q[GHB-1:0] : s2_q.gh;
    gc_wdata = clearing_q ? GC_INIT : gc_new;
    lh_we    = clearing_q || s1_v_q;
    lh_waddr = clearing_q ? clr_q[PIB-1:0] : s1_q.pc;
    lh_wdata = clearing_q ? '1 : lh_new;
    lc_we    = clearing_q || s2_v_q;
    lc_waddr = clearing_q ? clr_q[LHB-1:0] : s2_q.lh;
    lc_wdata = clearing_q ? LC_INIT : lc_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      lhw_v_q    <= 1'b0;
      gcw_v_q    <= 1'b0;
      lcw_v_q    <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
      s1_v_q     <= head_pop_o;
      s2_v_q     <= s1_v_q;
      lhw_v_q    <= s1_v_q;
      gcw_v_q    <= s2_v_q;
      lcw_v_q    <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    lhw_q <= lhw_d;
    gcw_q <= gcw_d;
    lcw_q <= lcw_d;
  end

  tbp_ram #(
    .WIDTH ($bits(gc_word_t)),
    .DEPTH (1 << GHB)
  ) u_gc_ram (
    .clk_i   (clk_i),
    .we_i    (gc_we),
    .waddr_i (gc_waddr),
    .wdata_i (gc_wdata),
    .raddr_i (head_gh_i),
    .rdata_o (gc_rdata)
  );

  tbp_ram #(
    .WIDTH (LHB),
    .DEPTH (1 << PIB)
  ) u_lh_ram (
    .clk_i   (clk_i),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (lh_wdata),
    .raddr_i (head_pc),
    .rdata_o (lh_rdata)
  );

  tbp_ram #(
    .WIDTH (LCB),
    .DEPTH (1 << LHB)
  ) u_lc_ram (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .raddr_i (lh_eff),
    .rdata_o (lc_rdata)
  );

  tbp_fifo #(
    .WIDTH ($bits(tbp_rsp_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_v_q),
    .data_i  (rsp_d),
    .pop_i   (pop_i),
    .data_o  (rsp_o),
    .full_o  (),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tournament_branch_predictor_top.sv =====
// Top level of the tournament branch predictor.
`default_nettype none

// Takes one resolved branch request per cycle while full is low and returns, in order,
// the prediction made before training, the component the chooser picked and whether
// it missed. While results are popped the sustained rate is one request per cycle,
// set by the single read and single write port of each table, with forwarding
// covering back-to-back hits on the same entry. After reset a clearing pass over
// 2^max(GLOBAL_HISTORY_BITS, LOCAL_HISTORY_BITS, PC_INDEX_BITS) entries (4096 at
// the defaults) initializes all tables; full stays high until it ends.
module tournament_branch_predictor_top #(
  parameter int GLOBAL_HISTORY_BITS = tbp_pkg::GLOBAL_HISTORY_BITS_DEF,
  parameter int LOCAL_HISTORY_BITS  = tbp_pkg::LOCAL_HISTORY_BITS_DEF,
  parameter int PC_INDEX_BITS       = tbp_pkg::PC_INDEX_BITS_DEF,
  parameter int GLOBAL_COUNTER_BITS = tbp_pkg::GLOBAL_COUNTER_BITS_DEF,
  parameter int LOCAL_COUNTER_BITS  = tbp_pkg::LOCAL_COUNTER_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire tbp_pkg::tbp_req_t req_i,
  output logic                   empty,
  input  wire logic              pop,
  output tbp_pkg::tbp_rsp_t      rsp_o
);

  import tbp_pkg::*;

  logic                           clearing;
  logic                           head_valid;
  logic                           head_pop;
  tbp_req_t                       head_req;
  logic [GLOBAL_HISTORY_BITS-1:0] head_gh;

  tbp_front #(
    .GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (clearing),
    .push_i       (push),
    .req_i        (req_i),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_req_o   (head_req),
    .head_gh_o    (head_gh),
    .head_pop_i   (head_pop)
  );

  tbp_back #(
    .GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS),
    .LOCAL_HISTORY_BITS  (LOCAL_HISTORY_BITS),
    .PC_INDEX_BITS       (PC_INDEX_BITS),
    .GLOBAL_COUNTER_BITS (GLOBAL_COUNTER_BITS),
    .LOCAL_COUNTER_BITS  (LOCAL_COUNTER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_o   (clearing),
    .head_valid_i (head_valid),
    .head_req_i   (head_req),
    .head_gh_i    (head_gh),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .rsp_o        (rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tbp_checker.sv =====
// Port-level assertions for the tournament branch predictor, bound to the top level.
`default_nettype none

module tbp_props (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              push,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire tbp_pkg::tbp_rsp_t rsp_o
);

  import tbp_pkg::*;

  localparam int CAP = MID_DEPTH + OUT_DEPTH;
  localparam int OW  = $clog2(CAP + 1);

  logic [OW-1:0] outstanding_q, outstanding_d;
  logic          in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   outstanding_d = outstanding_q + 1'b1;
      2'b01:   outstanding_d = outstanding_q - 1'b1;
      default: outstanding_d = outstanding_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> full && empty)
    else $error("requests accepted or results shown during reset");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> outstanding_q != '0)
    else $error("result shown with no request outstanding");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q == OW'(CAP) |-> full)
    else $error("request accepted beyond internal capacity");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(rsp_o))
    else $error("stalled result changed or vanished");

endmodule

bind tournament_branch_predictor_top tbp_props u_checker (.*);

`default_nettype wire
